FILE: src/triangle_measure_classify_top_macros.svh
// ----------------------------------------------------------------------------
// triangle_measure_classify_top_macros
// Assertion helpers for the triangle measure block. Both sample on the rising
// edge of i_clk and are switched off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_MEASURE_CLASSIFY_TOP_MACROS_SVH
`define TRIANGLE_MEASURE_CLASSIFY_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TMC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("triangle_measure_classify: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TMC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("triangle_measure_classify: assertion failed");

`endif

FILE: src/tmc_pkg.sv
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared widths, defaults and types of the triangle measure pipeline.
// ----------------------------------------------------------------------------
package tmc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    // Result field widths
    localparam int PERIM_W = 27;
    localparam int AREA_W  = 33;
    localparam int SHAPE_W = 2;

    // Register stages in front of the square root pipeline
    localparam int FRONT_LAT = 4;

    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_EQUI = 2'd0,
        SHAPE_ISO  = 2'd1,
        SHAPE_SCAL = 2'd2
    } t_shape;

    // Results that ride alongside the root pipeline
    typedef struct packed {
        logic [AREA_W-1:0] area;
        t_shape            shape;
    } t_side;

endpackage

FILE: src/tmc_front.sv
// ----------------------------------------------------------------------------
// tmc_front
// Edge vectors, squared lengths, cross product, absolute area and shape
// compare, in four register stages.
// ----------------------------------------------------------------------------
module tmc_front #(
    parameter int COORD_BITS = tmc_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [COORD_BITS-1:0]        i_ax,
    input  logic signed [COORD_BITS-1:0]        i_ay,
    input  logic signed [COORD_BITS-1:0]        i_bx,
    input  logic signed [COORD_BITS-1:0]        i_by,
    input  logic signed [COORD_BITS-1:0]        i_cx,
    input  logic signed [COORD_BITS-1:0]        i_cy,
    output logic                                o_valid,
    output logic [2:0][2*COORD_BITS:0]          o_dsq,
    output tmc_pkg::t_side                      o_side
);

    localparam int DF_W = COORD_BITS + 1;       // edge component
    localparam int PR_W = 2 * DF_W;             // signed product
    localparam int SQ_W = 2 * COORD_BITS;       // one square
    localparam int D_W  = 2 * COORD_BITS + 1;   // squared length
    localparam int X_W  = PR_W + 1;             // cross product

    logic [3:0] r_vld;

    // stage 1
    logic signed [DF_W-1:0] r1_xab, r1_yab, r1_xbc, r1_ybc, r1_xac, r1_yac;
    // stage 2
    logic [SQ_W-1:0]        r2_xab, r2_yab, r2_xbc, r2_ybc, r2_xac, r2_yac;
    logic signed [PR_W-1:0] r2_c1, r2_c2;
    // stage 3
    logic [D_W-1:0]         r3_dab, r3_dbc, r3_dac;
    logic signed [X_W-1:0]  r3_cross;
    // stage 4
    logic [D_W-1:0]         r4_dab, r4_dbc, r4_dac;
    tmc_pkg::t_side         r4_side;

    logic signed [DF_W-1:0] ax_e, ay_e, bx_e, by_e, cx_e, cy_e;
    logic signed [PR_W-1:0] p_xab, p_yab, p_xbc, p_ybc, p_xac, p_yac;
    logic signed [PR_W-1:0] p_c1, p_c2;
    logic [X_W-1:0]         abs_cross;
    logic [X_W+tmc_pkg::AREA_W-1:0] area_ext;
    tmc_pkg::t_shape        n_shape;
    logic                   eq_ab_bc, eq_ab_ac, eq_bc_ac;

    assign ax_e = {i_ax[COORD_BITS-1], i_ax};
    assign ay_e = {i_ay[COORD_BITS-1], i_ay};
    assign bx_e = {i_bx[COORD_BITS-1], i_bx};
    assign by_e = {i_by[COORD_BITS-1], i_by};
    assign cx_e = {i_cx[COORD_BITS-1], i_cx};
    assign cy_e = {i_cy[COORD_BITS-1], i_cy};

    assign p_xab = r1_xab * r1_xab;
    assign p_yab = r1_yab * r1_yab;
    assign p_xbc = r1_xbc * r1_xbc;
    assign p_ybc = r1_ybc * r1_ybc;
    assign p_xac = r1_xac * r1_xac;
    assign p_yac = r1_yac * r1_yac;
    assign p_c1  = r1_xab * r1_yac;
    assign p_c2  = r1_yab * r1_xac;

    always_comb begin
        abs_cross = r3_cross[X_W-1] ? X_W'(-r3_cross) : X_W'(r3_cross);
        area_ext  = {{tmc_pkg::AREA_W{1'b0}}, abs_cross};
        eq_ab_bc  = (r3_dab == r3_dbc);
        eq_ab_ac  = (r3_dab == r3_dac);
        eq_bc_ac  = (r3_dbc == r3_dac);
        if (eq_ab_bc && eq_bc_ac) begin
            n_shape = tmc_pkg::SHAPE_EQUI;
        end else if (eq_ab_bc || eq_ab_ac || eq_bc_ac) begin
            n_shape = tmc_pkg::SHAPE_ISO;
        end else begin
            n_shape = tmc_pkg::SHAPE_SCAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_xab <= bx_e - ax_e;
        r1_yab <= by_e - ay_e;
        r1_xbc <= cx_e - bx_e;
        r1_ybc <= cy_e - by_e;
        r1_xac <= cx_e - ax_e;
        r1_yac <= cy_e - ay_e;

        // squares are never negative and stay below 2^SQ_W
        r2_xab <= p_xab[SQ_W-1:0];
        r2_yab <= p_yab[SQ_W-1:0];
        r2_xbc <= p_xbc[SQ_W-1:0];
        r2_ybc <= p_ybc[SQ_W-1:0];
        r2_xac <= p_xac[SQ_W-1:0];
        r2_yac <= p_yac[SQ_W-1:0];
        r2_c1  <= p_c1;
        r2_c2  <= p_c2;

        r3_dab   <= {1'b0, r2_xab} + {1'b0, r2_yab};
        r3_dbc   <= {1'b0, r2_xbc} + {1'b0, r2_ybc};
        r3_dac   <= {1'b0, r2_xac} + {1'b0, r2_yac};
        r3_cross <= {r2_c1[PR_W-1], r2_c1} - {r2_c2[PR_W-1], r2_c2};

        r4_dab        <= r3_dab;
        r4_dbc        <= r3_dbc;
        r4_dac        <= r3_dac;
        r4_side.area  <= area_ext[tmc_pkg::AREA_W-1:0];
        r4_side.shape <= n_shape;
    end

    assign o_valid = r_vld[3];
    assign o_dsq   = {r4_dac, r4_dbc, r4_dab};
    assign o_side  = r4_side;

endmodule

FILE: src/tmc_root.sv
// ----------------------------------------------------------------------------
// tmc_root
// Three-lane pipelined integer square root of d * 4^FRAC_BITS, one root bit
// per stage (restoring digit recurrence). Side results travel along.
// ----------------------------------------------------------------------------
module tmc_root #(
    parameter int COORD_BITS = tmc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tmc_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [2:0][2*COORD_BITS:0]             i_dsq,
    input  tmc_pkg::t_side                         i_side,
    output logic                                   o_valid,
    output logic [2:0][COORD_BITS+FRAC_BITS:0]     o_root,
    output tmc_pkg::t_side                         o_side
);

    localparam int D_W   = 2 * COORD_BITS + 1;
    localparam int RAD_W = D_W + 2 * FRAC_BITS;
    localparam int R_W   = COORD_BITS + FRAC_BITS + 1;
    localparam int PAD_W = 2 * R_W;
    localparam int REM_W = R_W + 2;

    logic [REM_W-1:0]  r_rem  [R_W][3];
    logic [R_W-1:0]    r_q    [R_W][3];
    logic [PAD_W-1:0]  r_rad  [R_W][3];
    logic              r_vld  [R_W];
    tmc_pkg::t_side    r_side [R_W];

    for (genvar k = 0; k < R_W; k++) begin : g_stage
        logic [REM_W-1:0] rem_in  [3];
        logic [R_W-1:0]   q_in    [3];
        logic [PAD_W-1:0] rad_in  [3];
        logic             vld_in;
        tmc_pkg::t_side   side_in;
        logic [REM_W-1:0] cur     [3];
        logic [REM_W:0]   trial   [3];
        logic [REM_W-1:0] n_rem   [3];
        logic [R_W-1:0]   n_q     [3];
        logic [PAD_W-1:0] n_rad   [3];

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    rem_in[l] = '0;
                    q_in[l]   = '0;
                    rad_in[l] = PAD_W'(RAD_W'(i_dsq[l]) << (2 * FRAC_BITS));
                end
                vld_in  = i_valid;
                side_in = i_side;
            end
        end else begin : g_next
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    rem_in[l] = r_rem[k-1][l];
                    q_in[l]   = r_q[k-1][l];
                    rad_in[l] = r_rad[k-1][l];
                end
                vld_in  = r_vld[k-1];
                side_in = r_side[k-1];
            end
        end

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                // bring down the next two radicand bits, try root bit one
                cur[l]   = {rem_in[l][REM_W-3:0], rad_in[l][PAD_W-1 -: 2]};
                trial[l] = {1'b0, cur[l]} - {1'b0, q_in[l], 2'b01};
                n_rem[l] = trial[l][REM_W] ? cur[l] : trial[l][REM_W-1:0];
                n_q[l]   = {q_in[l][R_W-2:0], ~trial[l][REM_W]};
                n_rad[l] = {rad_in[l][PAD_W-3:0], 2'b00};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            for (int l = 0; l < 3; l++) begin
                r_rem[k][l] <= n_rem[l];
                r_q[k][l]   <= n_q[l];
                r_rad[k][l] <= n_rad[l];
            end
            r_side[k] <= side_in;
        end
    end

    assign o_valid = r_vld[R_W-1];
    assign o_root  = {r_q[R_W-1][2], r_q[R_W-1][1], r_q[R_W-1][0]};
    assign o_side  = r_side[R_W-1];

endmodule

FILE: src/triangle_measure_classify_top.sv
// Path from start to o_valid: 4 front stages, one stage per root bit in the square
//   root pipeline, 1 sum stage.
// Throughput: one triangle per cycle; busy stays low, the pipeline never stalls.
// Reset (synchronous, active low) clears the valid bits only; items in flight are dropped.
// ----------------------------------------------------------------------------
// triangle_measure_classify_top
// Perimeter, twice the area and shape type of one triangle per cycle.
// ----------------------------------------------------------------------------
module triangle_measure_classify_top #(
    parameter int COORD_BITS = tmc_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tmc_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [COORD_BITS-1:0]     i_ax,
    input  logic signed [COORD_BITS-1:0]     i_ay,
    input  logic signed [COORD_BITS-1:0]     i_bx,
    input  logic signed [COORD_BITS-1:0]     i_by,
    input  logic signed [COORD_BITS-1:0]     i_cx,
    input  logic signed [COORD_BITS-1:0]     i_cy,
    output logic                             o_valid,
    output logic [tmc_pkg::PERIM_W-1:0]      o_perimeter_q8,
    output logic [tmc_pkg::AREA_W-1:0]       o_double_area,
    output logic [tmc_pkg::SHAPE_W-1:0]      o_shape_type
);

    localparam int D_W   = 2 * COORD_BITS + 1;
    localparam int R_W   = COORD_BITS + FRAC_BITS + 1;
    localparam int SUM_W = R_W + 2;
    localparam int LAT   = tmc_pkg::FRONT_LAT + R_W + 1;

    logic                    accept;
    logic                    f_valid;
    logic [2:0][D_W-1:0]     f_dsq;
    tmc_pkg::t_side          f_side;
    logic                    q_valid;
    logic [2:0][R_W-1:0]     q_root;
    tmc_pkg::t_side          q_side;
    logic [SUM_W-1:0]        perim_sum;
    logic [SUM_W+tmc_pkg::PERIM_W-1:0] perim_ext;

    logic                          r_valid;
    logic [tmc_pkg::PERIM_W-1:0]   r_perim;
    tmc_pkg::t_side                r_side;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    tmc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_ax    (i_ax),
        .i_ay    (i_ay),
        .i_bx    (i_bx),
        .i_by    (i_by),
        .i_cx    (i_cx),
        .i_cy    (i_cy),
        .o_valid (f_valid),
        .o_dsq   (f_dsq),
        .o_side  (f_side)
    );

    tmc_root #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_dsq   (f_dsq),
        .i_side  (f_side),
        .o_valid (q_valid),
        .o_root  (q_root),
        .o_side  (q_side)
    );

    always_comb begin
        perim_sum = SUM_W'(q_root[0]) + SUM_W'(q_root[1]) + SUM_W'(q_root[2]);
        perim_ext = {{tmc_pkg::PERIM_W{1'b0}}, perim_sum};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_perim <= perim_ext[tmc_pkg::PERIM_W-1:0];
        r_side  <= q_side;
    end

    assign o_valid        = r_valid;
    assign o_perimeter_q8 = r_perim;
    assign o_double_area  = r_side.area;
    assign o_shape_type   = r_side.shape;

`include "triangle_measure_classify_top_macros.svh"

    // every accepted item comes out on o_valid, and nothing else does
    `TMC_ASSERT_NEXT(a_lat_fwd, $past(accept, LAT - 1), o_valid)
    `TMC_ASSERT_IMP(a_lat_back, o_valid, $past(accept, LAT))
    // no lattice triangle is equilateral unless all vertices coincide
    `TMC_ASSERT_IMP(a_equi_flat, o_valid && (o_shape_type == tmc_pkg::SHAPE_EQUI), (o_double_area == '0) && (o_perimeter_q8 == '0))

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the triangle measure pipeline. It runs directed
// corner triangles, then random triangle streams under several start-gap
// profiles. A scoreboard predicts perimeter, twice the area and shape type
// for every accepted item and checks each strobed result in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W    = tmc_pkg::COORD_BITS_DEF;
    localparam int FRAC_W     = tmc_pkg::FRAC_BITS_DEF;
    localparam int PIPE_LAT   = COORD_W + FRAC_W + 6;
    localparam int N_RANDOM   = 280;
    localparam int DRAIN_MAX  = 20 * PIPE_LAT;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord ax, ay, bx, by, cx, cy;
    } t_tri_in;

    typedef struct {
        logic [tmc_pkg::PERIM_W-1:0] perim;
        logic [tmc_pkg::AREA_W-1:0]  area;
        tmc_pkg::t_shape             shape;
    } t_tri_result;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    t_coord                      i_ax, i_ay, i_bx, i_by, i_cx, i_cy;
    logic                        o_valid;
    logic [tmc_pkg::PERIM_W-1:0] o_perimeter_q8;
    logic [tmc_pkg::AREA_W-1:0]  o_double_area;
    logic [tmc_pkg::SHAPE_W-1:0] o_shape_type;

    t_tri_result pending_measures[$];
    int          mismatch_count = 0;
    int          measures_checked = 0;
    int          directed_sent = 0;
    int          random_sent = 0;
    int          shape_seen[3] = '{0, 0, 0};
    int          flat_seen = 0;

    triangle_measure_classify_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_ax           (i_ax),
        .i_ay           (i_ay),
        .i_bx           (i_bx),
        .i_by           (i_by),
        .i_cx           (i_cx),
        .i_cy           (i_cy),
        .o_valid        (o_valid),
        .o_perimeter_q8 (o_perimeter_q8),
        .o_double_area  (o_double_area),
        .o_shape_type   (o_shape_type)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #1ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned probe;
        res   = 0;
        probe = 64'h1 << 62;
        while (probe > n) probe >>= 2;
        while (probe != 0) begin
            if (n >= res + probe) begin
                n   -= res + probe;
                res  = (res >> 1) + probe;
            end else begin
                res >>= 1;
            end
            probe >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned side_sq(t_coord x0, t_coord y0, t_coord x1, t_coord y1);
        longint dx;
        longint dy;
        dx = longint'(x1) - longint'(x0);
        dy = longint'(y1) - longint'(y0);
        return longint'(dx * dx + dy * dy);
    endfunction

    function automatic t_tri_result measure_triangle(t_tri_in t);
        t_tri_result     r;
        longint unsigned d_ab, d_bc, d_ac;
        longint unsigned perim;
        longint          cross_prod;
        d_ab  = side_sq(t.ax, t.ay, t.bx, t.by);
        d_bc  = side_sq(t.bx, t.by, t.cx, t.cy);
        d_ac  = side_sq(t.ax, t.ay, t.cx, t.cy);
        perim = root_floor(d_ab << (2 * FRAC_W)) + root_floor(d_bc << (2 * FRAC_W))
              + root_floor(d_ac << (2 * FRAC_W));
        cross_prod = (longint'(t.bx) - longint'(t.ax)) * (longint'(t.cy) - longint'(t.ay))
                   - (longint'(t.by) - longint'(t.ay)) * (longint'(t.cx) - longint'(t.ax));
        if (cross_prod < 0) cross_prod = -cross_prod;
        r.perim = perim[tmc_pkg::PERIM_W-1:0];
        r.area  = cross_prod[tmc_pkg::AREA_W-1:0];
        if (d_ab == d_bc && d_bc == d_ac) r.shape = tmc_pkg::SHAPE_EQUI;
        else if (d_ab == d_bc || d_ab == d_ac || d_bc == d_ac) r.shape = tmc_pkg::SHAPE_ISO;
        else r.shape = tmc_pkg::SHAPE_SCAL;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: check the strobed result, then record the accepted item
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_tri_result want;
        t_tri_in     seen;
        if (i_rst_n && o_valid) begin
            if (pending_measures.size() == 0) begin
                $display("%0t unexpected result: expected none, got perim %0d area %0d shape %0d",
                         $time, o_perimeter_q8, o_double_area, o_shape_type);
                mismatch_count++;
            end else begin
                want = pending_measures.pop_front();
                measures_checked++;
                if (o_perimeter_q8 !== want.perim) begin
                    $display("%0t perimeter: expected %0d, got %0d",
                             $time, want.perim, o_perimeter_q8);
                    mismatch_count++;
                end
                if (o_double_area !== want.area) begin
                    $display("%0t double area: expected %0d, got %0d",
                             $time, want.area, o_double_area);
                    mismatch_count++;
                end
                if (o_shape_type !== want.shape) begin
                    $display("%0t shape type: expected %0d, got %0d",
                             $time, want.shape, o_shape_type);
                    mismatch_count++;
                end
                shape_seen[want.shape]++;
                if (want.area == 0) flat_seen++;
            end
        end
        if (i_rst_n && start && !busy) begin
            seen = '{ax: i_ax, ay: i_ay, bx: i_bx, by: i_by, cx: i_cx, cy: i_cy};
            pending_measures.push_back(measure_triangle(seen));
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_tri_in make_tri(int ax, int ay, int bx, int by, int cx, int cy);
        t_tri_in t;
        t.ax = t_coord'(ax);
        t.ay = t_coord'(ay);
        t.bx = t_coord'(bx);
        t.by = t_coord'(by);
        t.cx = t_coord'(cx);
        t.cy = t_coord'(cy);
        return t;
    endfunction

    // Caller is at a rising edge; returns at the edge that accepts the item.
    task automatic send_triangle(t_tri_in t);
        start <= 1'b1;
        i_ax  <= t.ax;
        i_ay  <= t.ay;
        i_bx  <= t.bx;
        i_by  <= t.by;
        i_cx  <= t.cx;
        i_cy  <= t.cy;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic wait_pipeline_empty();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_measures.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    function automatic t_tri_in pick_triangle();
        int sel, px, py, p, q, k, m;
        sel = $urandom_range(99);
        px  = int'($urandom_range(32767)) - 16384;
        py  = int'($urandom_range(32767)) - 16384;
        p   = int'($urandom_range(16383)) - 8192;
        q   = int'($urandom_range(16383)) - 8192;
        if (sel < 55) begin
            return make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (sel < 72) begin
            // equal legs from apex A: AC is AB turned a quarter
            return make_tri(px, py, px + p, py + q, px - q, py + p);
        end else if (sel < 87) begin
            // tight cluster so small equal sides show up by chance
            px = int'($urandom_range(65519)) - 32760;
            py = int'($urandom_range(65519)) - 32760;
            return make_tri(px + int'($urandom_range(8)) - 4, py + int'($urandom_range(8)) - 4,
                            px + int'($urandom_range(8)) - 4, py + int'($urandom_range(8)) - 4,
                            px + int'($urandom_range(8)) - 4, py + int'($urandom_range(8)) - 4);
        end else if (sel < 95) begin
            p = int'($urandom_range(127)) - 64;
            q = int'($urandom_range(127)) - 64;
            k = int'($urandom_range(200)) - 100;
            m = int'($urandom_range(200)) - 100;
            return make_tri(px, py, px + k * p, py + k * q, px + m * p, py + m * q);
        end else begin
            // two or three vertices on one point
            k = $urandom_range(2);
            if (k == 0) return make_tri(px, py, px, py, px, py);
            if (k == 1) return make_tri(px, py, px, py, px + p, py + q);
            return make_tri(px, py, px + p, py + q, px + p, py + q);
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_extreme_coords();
        t_tri_in list[$];
        list.push_back(make_tri(-32768, -32768, 32767, -32768, -32768, 32767));
        list.push_back(make_tri(32767, 32767, -32768, 32767, 32767, -32768));
        list.push_back(make_tri(-32768, -32768, 32767, 32767, -32768, 32767));
        list.push_back(make_tri(-32768, 32767, 32767, -32768, 0, 0));
        list.push_back(make_tri(-32768, 32767, 32767, -32768, 32767, 32767));
        list.push_back(make_tri(21845, -21846, -21846, 21845, 21845, 21845));
        list.push_back(make_tri(-21846, 21845, 21845, -21846, -21846, -21846));
        foreach (list[i]) send_triangle(list[i]);
        directed_sent += list.size();
    endtask

    task automatic test_degenerate_triangles();
        t_tri_in list[$];
        // coincident vertices
        list.push_back(make_tri(0, 0, 0, 0, 0, 0));
        list.push_back(make_tri(32767, 32767, 32767, 32767, 32767, 32767));
        list.push_back(make_tri(-32768, -32768, -32768, -32768, -32768, -32768));
        // collinear vertices
        list.push_back(make_tri(-32767, -32767, 0, 0, 32767, 32767));
        list.push_back(make_tri(-32768, 5, 100, 5, 32767, 5));
        list.push_back(make_tri(7, -32768, 7, 32767, 7, 0));
        // one repeated vertex
        list.push_back(make_tri(100, -200, 100, -200, -300, 400));
        list.push_back(make_tri(-300, 400, 100, -200, -300, 400));
        list.push_back(make_tri(-300, 400, 100, -200, 100, -200));
        foreach (list[i]) send_triangle(list[i]);
        directed_sent += list.size();
    endtask

    task automatic test_shape_types();
        t_tri_in list[$];
        list.push_back(make_tri(0, 0, 4, 0, 2, 5));
        list.push_back(make_tri(0, 0, 3, 0, 0, 4));
        list.push_back(make_tri(0, 0, 1, 0, 0, 1));
        list.push_back(make_tri(-1, -2, -5, -3, -2, -9));
        list.push_back(make_tri(10, 10, 13, 14, 6, 13));
        foreach (list[i]) send_triangle(list[i]);
        directed_sent += list.size();
    endtask

    // Per cycle, hold start low with probability idle_pct percent.
    task automatic test_random_stream(int idle_pct, int count);
        for (int n = 0; n < count; n++) begin
            while (int'($urandom_range(99)) < idle_pct) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
            send_triangle(pick_triangle());
        end
        random_sent += count;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_ax    <= '0;
        i_ay    <= '0;
        i_bx    <= '0;
        i_by    <= '0;
        i_cx    <= '0;
        i_cy    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extreme_coords();
        test_degenerate_triangles();
        test_shape_types();
        wait_pipeline_empty();

        test_random_stream(0, N_RANDOM);
        wait_pipeline_empty();
        test_random_stream(53, N_RANDOM);
        wait_pipeline_empty();
        test_random_stream(24, N_RANDOM);

        wait_pipeline_empty();
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (pending_measures.size() != 0) begin
            $display("%0t results missing: expected %0d more, got 0",
                     $time, pending_measures.size());
            mismatch_count += pending_measures.size();
        end

        $display("Checked %0d results from %0d directed and %0d random triangles",
                 measures_checked, directed_sent, random_sent);
        $display("Shapes: %0d equilateral, %0d isosceles, %0d scalene, %0d with zero area",
                 shape_seen[tmc_pkg::SHAPE_EQUI], shape_seen[tmc_pkg::SHAPE_ISO],
                 shape_seen[tmc_pkg::SHAPE_SCAL], flat_seen);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
